FILE: hdl/daoff_pkg.sv
// Shared types, constants and calendar tables for the date difference and offset unit.
package daoff_pkg;

	typedef struct packed {
		logic        cmd;
		logic [13:0] year_a;
		logic [3:0]  month_a;
		logic [4:0]  day_a;
		logic [13:0] year_b;
		logic [3:0]  month_b;
		logic [4:0]  day_b;
		logic [19:0] add_count;
	} request_t;

	typedef struct packed {
		logic signed [22:0] day_difference;
		logic [13:0]        out_year;
		logic [3:0]         out_month;
		logic [4:0]         out_day;
		logic               year_overflow;
	} result_t;

	// Linear day number, days from 0-01-01; reaches -1 for day 0 of year 0 January.
	typedef logic signed [23:0] daynum_t;

	// Fields that ride along the pipeline next to the date work.
	typedef struct packed {
		logic               cmd;
		logic signed [22:0] diff;
	} side_t;

	localparam logic        CMD_DIFF = 1'b0;
	localparam logic        CMD_ADD  = 1'b1;

	localparam logic signed [24:0] DIFF_LIMIT = 25'sd3652500;
	localparam logic [14:0] MAX_YEAR   = 15'd9999;
	localparam logic [10:0] CYCLE_DAYS = 11'd1461;
	localparam logic [8:0]  LEAP_DAYS  = 9'd366;
	localparam logic [8:0]  YEAR_DAYS  = 9'd365;
	// floor(2^32 / 1461); the quotient estimate is low by at most one
	localparam logic [21:0] RECIP       = 22'd2939744;
	localparam int          RECIP_SHIFT = 32;

	// Day of year at which each month starts in a common year.
	function automatic logic [8:0] month_start(input logic [3:0] idx);
		logic [8:0] s;
		case (idx)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd59;
			4'd3:    s = 9'd90;
			4'd4:    s = 9'd120;
			4'd5:    s = 9'd151;
			4'd6:    s = 9'd181;
			4'd7:    s = 9'd212;
			4'd8:    s = 9'd243;
			4'd9:    s = 9'd273;
			4'd10:   s = 9'd304;
			4'd11:   s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

FILE: hdl/daoff_daynum.sv
// Date to linear day number conversion.
module daoff_daynum (
	input  logic [13:0]      year,
	input  logic [3:0]       month,
	input  logic [4:0]       day,
	output daoff_pkg::daynum_t day_num
);

	logic [3:0]  m_idx;
	logic        leap_add;
	logic [14:0] leap_count;
	logic [22:0] base;

	always_comb begin
		if (month == 4'd0) begin
			m_idx = 4'd0;
		end else if (month > 4'd12) begin
			m_idx = 4'd11;
		end else begin
			m_idx = month - 4'd1;
		end
		leap_add   = (m_idx >= 4'd2) && (year[1:0] == 2'b00);
		leap_count = ({1'b0, year} + 15'd3) >> 2;
		base = 23'(year) * 23'd365 + 23'(leap_count) + 23'(daoff_pkg::month_start(m_idx))
			+ 23'(leap_add) + 23'(day);
		day_num = $signed({1'b0, base}) - 24'sd1;
	end

endmodule

FILE: hdl/daoff_divide.sv
// Two-stage division of the day number by the four-year cycle length.
module daoff_divide (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s2,
	input  logic [22:0]      n_s2,
	input  daoff_pkg::side_t side_s2,
	output logic             valid_s4,
	output logic [12:0]      q_s4,
	output logic [10:0]      r_s4,
	output daoff_pkg::side_t side_s4
);

	logic             valid_s3;
	logic [22:0]      n_s3;
	logic [12:0]      q0_s3;
	daoff_pkg::side_t side_s3;

	logic [44:0] prod;
	logic [22:0] r0;
	logic [12:0] q_fix;
	logic [10:0] r_fix;

	assign prod = 45'(n_s2) * 45'(daoff_pkg::RECIP);

	always_comb begin
		r0 = n_s3 - 23'(q0_s3) * 23'(daoff_pkg::CYCLE_DAYS);
		// estimate may be one short: correct once
		if (r0 >= 23'(daoff_pkg::CYCLE_DAYS)) begin
			q_fix = q0_s3 + 13'd1;
			r_fix = 11'(r0[11:0] - 12'(daoff_pkg::CYCLE_DAYS));
		end else begin
			q_fix = q0_s3;
			r_fix = r0[10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		n_s3    <= n_s2;
		q0_s3   <= prod[daoff_pkg::RECIP_SHIFT +: 13];
		side_s3 <= side_s2;
		q_s4    <= q_fix;
		r_s4    <= r_fix;
		side_s4 <= side_s3;
	end

endmodule

FILE: hdl/daoff_calendar.sv
// Cycle remainder to year, month and day, and final result register.
module daoff_calendar (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s4,
	input  logic [12:0]        q_s4,
	input  logic [10:0]        r_s4,
	input  daoff_pkg::side_t   side_s4,
	output logic               done,
	output daoff_pkg::result_t result
);

	logic             valid_s5;
	logic [14:0]      y_s5;
	logic [8:0]       doy_s5;
	logic             leap_s5;
	daoff_pkg::side_t side_s5;

	logic [10:0] t;
	logic [1:0]  k;
	logic [14:0] y_next;
	logic [8:0]  doy_next;
	logic        leap_next;

	logic [3:0]         m_idx;
	logic [8:0]         m_start;
	daoff_pkg::result_t res_next;

	// Stage 5: year inside the four-year cycle
	always_comb begin
		t = r_s4 - 11'(daoff_pkg::LEAP_DAYS);
		if (r_s4 < 11'(daoff_pkg::LEAP_DAYS)) begin
			leap_next = 1'b1;
			k         = 2'd0;
			y_next    = {q_s4, 2'b00};
			doy_next  = r_s4[8:0];
		end else begin
			leap_next = 1'b0;
			if (t >= 11'd730) begin
				k = 2'd2;
			end else if (t >= 11'(daoff_pkg::YEAR_DAYS)) begin
				k = 2'd1;
			end else begin
				k = 2'd0;
			end
			y_next   = {q_s4, 2'b00} + 15'd1 + 15'(k);
			doy_next = 9'(t - 11'(k) * 11'(daoff_pkg::YEAR_DAYS));
		end
	end

	// Stage 6: month search over the start table, then pick the result form
	always_comb begin
		m_idx = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s5 >= daoff_pkg::month_start(4'(i)) + 9'((i >= 2) && leap_s5)) begin
				m_idx = 4'(i);
			end
		end
		m_start = daoff_pkg::month_start(m_idx) + 9'((m_idx >= 4'd2) && leap_s5);

		res_next = '0;
		if (side_s5.cmd == daoff_pkg::CMD_DIFF) begin
			res_next.day_difference = side_s5.diff;
		end else if (y_s5 > daoff_pkg::MAX_YEAR) begin
			res_next.out_year      = 14'(daoff_pkg::MAX_YEAR);
			res_next.out_month     = 4'd12;
			res_next.out_day       = 5'd31;
			res_next.year_overflow = 1'b1;
		end else begin
			res_next.out_year  = y_s5[13:0];
			res_next.out_month = m_idx + 4'd1;
			res_next.out_day   = 5'(doy_s5 - m_start + 9'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
			done     <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		y_s5    <= y_next;
		doy_s5  <= doy_next;
		leap_s5 <= leap_next;
		side_s5 <= side_s4;
		result  <= res_next;
	end

endmodule

FILE: hdl/date_difference_and_offset_top.sv
// Top level of the date difference and offset unit.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------
//  request  | start, busy (always low)  | request (daoff_pkg::request_t)
//  result   | done, one cycle           | result  (daoff_pkg::result_t)
//
// Six register stages: day numbers, difference/sum, reciprocal multiply,
// quotient correction, year split, month search. Result is on the ports from the
// month search register, for one cycle; one request accepted every cycle.
// arst_n clears the stage valid bits; payload registers are not reset.
// The result side cannot stall, so the pipeline never holds and busy stays low.
module date_difference_and_offset_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  daoff_pkg::request_t request,
	output logic                done,
	output daoff_pkg::result_t  result
);

	daoff_pkg::daynum_t na, nb;

	logic               valid_s1;
	daoff_pkg::daynum_t na_s1, nb_s1;
	logic [19:0]        add_s1;
	logic               cmd_s1;

	logic               valid_s2;
	logic [22:0]        n_s2;
	daoff_pkg::side_t   side_s2;

	logic signed [24:0] sum, diff;
	logic signed [24:0] diff_sat;
	logic [22:0]        n_next;
	daoff_pkg::side_t   side_next;

	logic               valid_s4;
	logic [12:0]        q_s4;
	logic [10:0]        r_s4;
	daoff_pkg::side_t   side_s4;

	assign busy = 1'b0;

	daoff_daynum u_daynum_a (
		.year    (request.year_a),
		.month   (request.month_a),
		.day     (request.day_a),
		.day_num (na)
	);

	daoff_daynum u_daynum_b (
		.year    (request.year_b),
		.month   (request.month_b),
		.day     (request.day_b),
		.day_num (nb)
	);

	always_comb begin
		sum  = {na_s1[23], na_s1} + $signed({5'b0, add_s1});
		diff = {nb_s1[23], nb_s1} - {na_s1[23], na_s1};
		if (diff > daoff_pkg::DIFF_LIMIT) begin
			diff_sat = daoff_pkg::DIFF_LIMIT;
		end else if (diff < -daoff_pkg::DIFF_LIMIT) begin
			diff_sat = -daoff_pkg::DIFF_LIMIT;
		end else begin
			diff_sat = diff;
		end
		// clamp sums before 0-01-01 to day zero
		n_next         = sum[24] ? 23'd0 : sum[22:0];
		side_next.cmd  = cmd_s1;
		side_next.diff = diff_sat[22:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		na_s1   <= na;
		nb_s1   <= nb;
		add_s1  <= request.add_count;
		cmd_s1  <= request.cmd;
		n_s2    <= n_next;
		side_s2 <= side_next;
	end

	daoff_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.n_s2     (n_s2),
		.side_s2  (side_s2),
		.valid_s4 (valid_s4),
		.q_s4     (q_s4),
		.r_s4     (r_s4),
		.side_s4  (side_s4)
	);

	daoff_calendar u_calendar (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s4 (valid_s4),
		.q_s4     (q_s4),
		.r_s4     (r_s4),
		.side_s4  (side_s4),
		.done     (done),
		.result   (result)
	);

endmodule
